// ===== src/dbd_pkg.sv =====
// ---------------------------------------------------------------------------
// dbd_pkg
// Shared types, register codes and defaults for the detection box decoder.
// ---------------------------------------------------------------------------
package dbd_pkg;

	localparam int MaxClassesDef = 128;
	localparam int CfgIdxW       = 3;
	localparam int ThrW          = 17;
	localparam int ScaleW        = 31;
	localparam int LabelW        = 7;
	localparam int ScoreW        = 31;

	localparam logic [ThrW-1:0]   ThrReset   = 17'd16384;
	localparam logic [ScaleW-1:0] ScaleReset = 31'd65536;
	localparam logic [31:0]       OffReset   = 32'd0;
	localparam logic [7:0]        CountReset = 8'd80;

	typedef enum logic [CfgIdxW-1:0] {
		RegThreshold  = 3'd0,
		RegScale      = 3'd1,
		RegOffsetX    = 3'd2,
		RegOffsetY    = 3'd3,
		RegClassCount = 3'd4
	} cfg_reg_t;

	// one finished row handed from the accumulator to the box pipeline
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] w;
		logic signed [31:0] h;
		logic signed [31:0] obj;
		logic signed [31:0] best;
		logic [LabelW-1:0]  label;
	} row_t;

	// mapping configuration seen by the box pipeline
	typedef struct packed {
		logic [ThrW-1:0]    thr;
		logic [ScaleW-1:0]  scale;
		logic signed [31:0] off_x;
		logic signed [31:0] off_y;
	} map_cfg_t;

endpackage

// ===== src/dbd_row_acc.sv =====
// ---------------------------------------------------------------------------
// dbd_row_acc
// Collects one prediction row: holds the box values, tracks the best class
// and hands the finished row on through the s1 register.
// ---------------------------------------------------------------------------
module dbd_row_acc import dbd_pkg::*; #(
	parameter int MAX_CLASSES = MaxClassesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	input  logic [7:0]         class_count,
	output logic               row_valid_s1,
	output row_t               row_s1,
	input  logic               row_ready
);

	localparam int PosW = $clog2(MAX_CLASSES + 5);
	localparam int IdxW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam logic [7:0] MaxCount = 8'(MAX_CLASSES);

	logic [PosW-1:0]    pos_q;
	logic signed [31:0] box_q [5];
	logic signed [31:0] best_q;
	logic [IdxW-1:0]    idx_q;

	logic [7:0]         n_cls;
	logic [PosW-1:0]    last_pos;
	logic               is_last;
	logic               s1_ready;
	logic               accept;
	logic               take_new;
	logic signed [31:0] best_nxt;
	logic [IdxW-1:0]    idx_nxt;
	logic [IdxW+6:0]    idx_ext;

	always_comb begin
		if (class_count == 8'd0) begin
			n_cls = 8'd1;
		end else if (class_count > MaxCount) begin
			n_cls = MaxCount;
		end else begin
			n_cls = class_count;
		end
	end

	assign last_pos = PosW'(9'd4 + {1'b0, n_cls});
	// a shrunken class count ends the row as soon as the position passes it
	assign is_last  = (pos_q >= last_pos);
	assign s1_ready = !row_valid_s1 || row_ready;
	assign in_ready = !is_last || s1_ready;
	assign accept   = in_valid && in_ready;

	assign take_new = (pos_q == PosW'(5)) || (value > best_q);
	assign best_nxt = take_new ? value : best_q;
	assign idx_nxt  = take_new ? IdxW'(pos_q - PosW'(5)) : idx_q;
	assign idx_ext  = {7'd0, idx_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q < PosW'(5)) begin
				box_q[pos_q[2:0]] <= value;
			end else begin
				best_q <= best_nxt;
				idx_q  <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			row_valid_s1 <= accept && is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			row_s1.cx    <= box_q[0];
			row_s1.cy    <= box_q[1];
			row_s1.w     <= box_q[2];
			row_s1.h     <= box_q[3];
			row_s1.obj   <= box_q[4];
			row_s1.best  <= best_nxt;
			row_s1.label <= idx_ext[6:0];
		end
	end

endmodule

// ===== src/dbd_box_pipe.sv =====
// ---------------------------------------------------------------------------
// dbd_box_pipe
// Score product and thresholds, corner forming, scaling, offset and
// saturation, ending in the output register.
// ---------------------------------------------------------------------------
module dbd_box_pipe import dbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  map_cfg_t            cfg,
	input  logic                row_valid_s1,
	input  row_t                row_s1,
	output logic                row_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  x_min,
	output logic signed [31:0]  y_min,
	output logic signed [31:0]  x_max,
	output logic signed [31:0]  y_max,
	output logic [LabelW-1:0]   class_label,
	output logic [ScoreW-1:0]   score
);

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat33 = v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		if ((&v[47:31]) || !(|v[47:31])) begin
			sat48 = v[31:0];
		end else begin
			sat48 = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	endfunction

	// stage 2: corners and raw score product
	logic               valid_s2;
	logic signed [31:0] xa_s2, ya_s2, xb_s2, yb_s2;
	logic signed [63:0] prod_s2;
	logic [LabelW-1:0]  label_s2;

	// stage 3: scaled corners and checked score
	logic               valid_s3;
	logic signed [47:0] xa_s3, ya_s3, xb_s3, yb_s3;
	logic [ScoreW-1:0]  score_s3;
	logic [LabelW-1:0]  label_s3;

	logic ready_s2, ready_s3, ready_out;

	logic signed [31:0] hw, hh;
	logic               obj_ok;
	logic signed [47:0] sc;
	logic               sc_ok;
	logic signed [31:0] scale_s;
	logic signed [63:0] mxa, mya, mxb, myb;
	logic signed [47:0] off_x48, off_y48;

	assign ready_out = !out_valid || out_ready;
	assign ready_s3  = !valid_s3 || ready_out;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign row_ready = ready_s2;

	// floor halving of the box size
	assign hw     = row_s1.w >>> 1;
	assign hh     = row_s1.h >>> 1;
	assign obj_ok = row_s1.obj >= $signed({15'd0, cfg.thr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= row_valid_s1 && obj_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && row_valid_s1) begin
			xa_s2    <= sat33(33'(row_s1.cx) - 33'(hw));
			xb_s2    <= sat33(33'(row_s1.cx) + 33'(hw));
			ya_s2    <= sat33(33'(row_s1.cy) - 33'(hh));
			yb_s2    <= sat33(33'(row_s1.cy) + 33'(hh));
			prod_s2  <= row_s1.best * row_s1.obj;
			label_s2 <= row_s1.label;
		end
	end

	// arithmetic shift of the exact product is the floor of the quotient
	assign sc      = prod_s2[63:16];
	assign sc_ok   = sc >= $signed({31'd0, cfg.thr});
	assign scale_s = $signed({1'b0, cfg.scale});
	assign mxa     = scale_s * xa_s2;
	assign mya     = scale_s * ya_s2;
	assign mxb     = scale_s * xb_s2;
	assign myb     = scale_s * yb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2 && sc_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			xa_s3    <= mxa[63:16];
			ya_s3    <= mya[63:16];
			xb_s3    <= mxb[63:16];
			yb_s3    <= myb[63:16];
			// score passed the threshold so it is never negative here
			score_s3 <= (|sc[47:31]) ? {ScoreW{1'b1}} : sc[30:0];
			label_s3 <= label_s2;
		end
	end

	assign off_x48 = 48'(cfg.off_x);
	assign off_y48 = 48'(cfg.off_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_out) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			x_min       <= sat48(xa_s3 + off_x48);
			y_min       <= sat48(ya_s3 + off_y48);
			x_max       <= sat48(xb_s3 + off_x48);
			y_max       <= sat48(yb_s3 + off_y48);
			class_label <= label_s3;
			score       <= score_s3;
		end
	end

endmodule

// ===== src/detection_box_decoder_top.sv =====
// ---------------------------------------------------------------------------
// detection_box_decoder_top
// s1 loads with the transfer of the last class value of a row; the box then
// moves through s2, s3 and the output register, where it becomes valid.
// Throughput: one value per cycle while in_ready is high; at most one box
// per row, set by the single-value row accumulator. Reset clears the row
// position, all valid flags and the registers to their defaults; held row
// values need no reset.
// ---------------------------------------------------------------------------
module detection_box_decoder_top import dbd_pkg::*; #(
	parameter int MAX_CLASSES = MaxClassesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_min,
	output logic signed [31:0] y_min,
	output logic signed [31:0] x_max,
	output logic signed [31:0] y_max,
	output logic [LabelW-1:0]  class_label,
	output logic [ScoreW-1:0]  score
);

	map_cfg_t   cfg_q;
	logic [7:0] class_count_q;
	logic       row_valid_s1;
	row_t       row_s1;
	logic       row_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr     <= ThrReset;
			cfg_q.scale   <= ScaleReset;
			cfg_q.off_x   <= OffReset;
			cfg_q.off_y   <= OffReset;
			class_count_q <= CountReset;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				RegThreshold:  cfg_q.thr     <= wr_data[ThrW-1:0];
				RegScale:      cfg_q.scale   <= wr_data[ScaleW-1:0];
				RegOffsetX:    cfg_q.off_x   <= wr_data;
				RegOffsetY:    cfg_q.off_y   <= wr_data;
				RegClassCount: class_count_q <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	dbd_row_acc #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_row_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.class_count (class_count_q),
		.row_valid_s1(row_valid_s1),
		.row_s1      (row_s1),
		.row_ready   (row_ready)
	);

	dbd_box_pipe u_box_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.row_valid_s1(row_valid_s1),
		.row_s1      (row_s1),
		.row_ready   (row_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.x_min       (x_min),
		.y_min       (y_min),
		.x_max       (x_max),
		.y_max       (y_max),
		.class_label (class_label),
		.score       (score)
	);

endmodule
